### design/led_pfe_pkg.sv
// ----------------------------------------------------------------------------
// led_pfe_pkg
// Shared codes, constants and types of the LED pixel fade engine.
// ----------------------------------------------------------------------------
package led_pfe_pkg;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_TICK    = 3'd1,
    CMD_STEP    = 3'd2,
    CMD_REVERSE = 3'd3,
    CMD_STOP    = 3'd4,
    CMD_READ    = 3'd5
  } cmd_e;

  // configuration register indexes
  localparam logic [1:0] CFG_FADE_IN_ONLY = 2'd0;
  localparam logic [1:0] CFG_PIXEL_COUNT  = 2'd1;

  // 3:3:2 code packing and expansion masks
  localparam logic [7:0] CODE_KEEP  = 8'hC0;
  localparam logic [7:0] EXP_R_MASK = 8'hE0;
  localparam logic [7:0] EXP_G_MASK = 8'h1C;
  localparam logic [7:0] EXP_B_MASK = 8'h03;

  typedef struct packed {
    logic [23:0] color;
    logic        reached;
  } pixel_step_t;

endpackage

### design/led_pfe_step.sv
// ----------------------------------------------------------------------------
// led_pfe_step
// Moves one pixel colour by one fade step towards its target or black.
// ----------------------------------------------------------------------------
module led_pfe_step #(
  parameter int FADE_STEPS = 80
) (
  input  logic [23:0]              color_i,
  input  logic [7:0]               code_i,
  input  logic                     up_i,
  output led_pfe_pkg::pixel_step_t step_o
);

  logic [7:0] step_rg_tab [8];
  logic [7:0] step_b_tab  [4];

  // step per channel is expanded target / FADE_STEPS + 1, one entry per code value
  for (genvar k = 0; k < 8; k++) begin : g_rg_tab
    localparam int StepRg = ((k * 32) / FADE_STEPS) + 1;
    assign step_rg_tab[k] = 8'(StepRg);
  end
  for (genvar k = 0; k < 4; k++) begin : g_b_tab
    localparam int StepB = ((k * 64) / FADE_STEPS) + 1;
    assign step_b_tab[k] = 8'(StepB);
  end

  logic [7:0] tgt  [3];
  logic [7:0] stp  [3];
  logic [7:0] cur  [3];
  logic [7:0] nxt  [3];
  logic [2:0] hit;

  always_comb begin
    tgt[2] = code_i & led_pfe_pkg::EXP_R_MASK;
    tgt[1] = (code_i & led_pfe_pkg::EXP_G_MASK) << 3;
    tgt[0] = (code_i & led_pfe_pkg::EXP_B_MASK) << 6;
    stp[2] = step_rg_tab[code_i[7:5]];
    stp[1] = step_rg_tab[code_i[4:2]];
    stp[0] = step_b_tab[code_i[1:0]];
    cur[2] = color_i[23:16];
    cur[1] = color_i[15:8];
    cur[0] = color_i[7:0];
    for (int c = 0; c < 3; c++) begin
      logic [7:0] goal;
      goal = (cur[c] > tgt[c]) ? cur[c] : tgt[c];
      if (up_i) begin
        if ((goal - cur[c]) <= stp[c]) begin
          nxt[c] = goal;
          hit[c] = 1'b1;
        end else begin
          nxt[c] = cur[c] + stp[c];
          hit[c] = 1'b0;
        end
      end else begin
        if (cur[c] > stp[c]) begin
          nxt[c] = cur[c] - stp[c];
          hit[c] = 1'b0;
        end else begin
          nxt[c] = 8'd0;
          hit[c] = 1'b1;
        end
      end
    end
    step_o.color   = {nxt[2], nxt[1], nxt[0]};
    step_o.reached = &hit;
  end

endmodule

### design/led_pixel_fade_engine_core.sv
// ----------------------------------------------------------------------------
// led_pixel_fade_engine_core
// Per-pixel colour fade engine with a command channel and a result channel.
// ----------------------------------------------------------------------------
// Usage: each command item (cmd, pixel_index, start_color) accepted on the
// input channel yields exactly one result item, which reports the fade
// counters and the addressed pixel as they stand after the command.
// Colour and target code live in one single-port-read synchronous memory;
// fading, direction and written flags are flip-flops cleared at reset.
// Flow: start, stop, read, reverse-all and a step on a pixel that is not
// fading go through the execute, result-read and result-output states to a
// loaded result; a step on a fading pixel and a tick also walk, a tick over n
// pixels where n is min(pixel_count, NUM_PIXELS), reading one pixel per cycle
// and writing it back the next, overlapped across neighbouring pixels.
// One item is worked at a time; a new item is taken as soon as the previous
// result sits in the output register, even while the receiver stalls.
// A stalled result holds the engine in its last state until taken.
// Configuration writes are always ready and take effect at once.
// Reset blacks every pixel, clears all flags and counters, sets fade_in_only
// to 0 and pixel_count to 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
module led_pixel_fade_engine_core #(
  parameter int NUM_PIXELS = 64,
  parameter int FADE_STEPS = 80
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  pixel_index_i,
  input  logic [23:0] start_color_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        updated_o,
  output logic [7:0]  went_out_o,
  output logic [7:0]  fading_count_o,
  output logic [23:0] pixel_color_o,
  output logic [7:0]  target_code_o,
  output logic        is_fading_o,
  output logic        is_increasing_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam logic [7:0] NumPix = 8'(NUM_PIXELS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_RES_RD,
    S_RES_OUT
  } state_e;

  typedef struct packed {
    logic [23:0] color;
    logic [7:0]  code;
  } entry_t;

  // pixel store
  entry_t          mem [NUM_PIXELS];
  entry_t          rdata_q;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;

  state_e          state_q, state_d;
  logic [2:0]      cmd_q, cmd_d;
  logic [7:0]      idx_q, idx_d;
  logic [23:0]     col_q, col_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [7:0]      lim_q, lim_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   wr_addr_q, wr_addr_d;
  logic [NUM_PIXELS-1:0] fading_q, fading_d;
  logic [NUM_PIXELS-1:0] dir_q, dir_d;
  logic [NUM_PIXELS-1:0] cval_q, cval_d;
  logic [7:0]      gone_q, gone_d;
  logic [7:0]      ftot_q, ftot_d;
  logic            upd_q, upd_d;
  logic            fio_q, fio_d;
  logic [7:0]      pcount_q, pcount_d;

  logic            out_valid_q, out_valid_d;
  logic            o_upd_q, o_upd_d;
  logic [7:0]      o_gone_q, o_gone_d;
  logic [7:0]      o_ftot_q, o_ftot_d;
  logic [23:0]     o_col_q, o_col_d;
  logic [7:0]      o_code_q, o_code_d;
  logic            o_fad_q, o_fad_d;
  logic            o_dir_q, o_dir_d;

  logic            idx_ok;
  logic [AW-1:0]   ia;
  logic [7:0]      walk_n;
  logic [7:0]      start_code;
  logic [23:0]     cur_color;
  led_pfe_pkg::pixel_step_t step;

  assign idx_ok     = idx_q < NumPix;
  assign ia         = idx_q[AW-1:0];
  assign walk_n     = (pcount_q < NumPix) ? pcount_q : NumPix;
  assign start_code = (col_q[23:16] & led_pfe_pkg::CODE_KEEP)
                    | ((col_q[15:8] & led_pfe_pkg::CODE_KEEP) >> 3)
                    | ((col_q[7:0] & led_pfe_pkg::CODE_KEEP) >> 6);
  // a pixel never written since reset is black
  assign cur_color  = cval_q[wr_addr_q] ? rdata_q.color : 24'h0;

  led_pfe_step #(
    .FADE_STEPS(FADE_STEPS)
  ) u_step (
    .color_i(cur_color),
    .code_i (rdata_q.code),
    .up_i   (dir_q[wr_addr_q]),
    .step_o (step)
  );

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    col_d       = col_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    pend_d      = pend_q;
    wr_addr_d   = wr_addr_q;
    fading_d    = fading_q;
    dir_d       = dir_q;
    cval_d      = cval_q;
    gone_d      = gone_q;
    ftot_d      = ftot_q;
    upd_d       = upd_q;
    fio_d       = fio_q;
    pcount_d    = pcount_q;
    out_valid_d = out_valid_q;
    o_upd_d     = o_upd_q;
    o_gone_d    = o_gone_q;
    o_ftot_d    = o_ftot_q;
    o_col_d     = o_col_q;
    o_code_d    = o_code_q;
    o_fad_d     = o_fad_q;
    o_dir_d     = o_dir_q;
    mem_re      = 1'b0;
    mem_raddr   = ia;
    mem_we      = 1'b0;
    mem_waddr   = ia;
    mem_wdata   = '{color: 24'h0, code: start_code};
    in_ready_o  = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        led_pfe_pkg::CFG_FADE_IN_ONLY: fio_d    = cfg_data_i[0];
        led_pfe_pkg::CFG_PIXEL_COUNT:  pcount_d = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          idx_d   = pixel_index_i;
          col_d   = start_color_i;
          upd_d   = 1'b0;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_RES_RD;
        case (cmd_q)
          led_pfe_pkg::CMD_START: begin
            if (idx_ok) begin
              if (!fading_q[ia]) begin
                ftot_d = ftot_q + 8'd1;
              end
              fading_d[ia] = 1'b1;
              dir_d[ia]    = 1'b1;
              cval_d[ia]   = 1'b1;
              mem_we       = 1'b1;
            end
          end
          led_pfe_pkg::CMD_TICK: begin
            gone_d  = 8'd0;
            cnt_d   = 8'd0;
            lim_d   = walk_n;
            pend_d  = 1'b0;
            state_d = S_WALK;
          end
          led_pfe_pkg::CMD_STEP: begin
            // a walk of one pixel starting at the addressed one
            if (idx_ok && fading_q[ia]) begin
              cnt_d   = idx_q;
              lim_d   = idx_q + 8'd1;
              pend_d  = 1'b0;
              state_d = S_WALK;
            end
          end
          led_pfe_pkg::CMD_REVERSE: begin
            for (int i = 0; i < NUM_PIXELS; i++) begin
              if ((8'(i) < walk_n) && fading_q[i]) begin
                dir_d[i] = 1'b0;
              end
            end
          end
          led_pfe_pkg::CMD_STOP: begin
            if (idx_ok && fading_q[ia]) begin
              fading_d[ia] = 1'b0;
              if (ftot_q != 8'd0) begin
                ftot_d = ftot_q - 8'd1;
              end
            end
          end
          default: ;
        endcase
      end

      S_WALK: begin
        // read pixel cnt while pixel cnt-1 is written back
        if (cnt_q < lim_q) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_q[AW-1:0];
          wr_addr_d = cnt_q[AW-1:0];
          cnt_d     = cnt_q + 8'd1;
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_RES_RD;
          end
        end
        if (pend_q && fading_q[wr_addr_q]) begin
          upd_d             = 1'b1;
          mem_we            = 1'b1;
          mem_waddr         = wr_addr_q;
          mem_wdata         = '{color: step.color, code: rdata_q.code};
          cval_d[wr_addr_q] = 1'b1;
          if (step.reached) begin
            if (dir_q[wr_addr_q] && !fio_q) begin
              dir_d[wr_addr_q] = 1'b0;
            end else begin
              fading_d[wr_addr_q] = 1'b0;
              if (ftot_q != 8'd0) begin
                ftot_d = ftot_q - 8'd1;
              end
              if (gone_q != 8'hFF) begin
                gone_d = gone_q + 8'd1;
              end
            end
          end
        end
      end

      S_RES_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ia;
        state_d   = S_RES_OUT;
      end

      S_RES_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_upd_d     = upd_q;
          o_gone_d    = gone_q;
          o_ftot_d    = ftot_q;
          o_col_d     = (idx_ok && cval_q[ia]) ? rdata_q.color : 24'h0;
          o_code_d    = idx_ok ? rdata_q.code : 8'h0;
          o_fad_d     = idx_ok && fading_q[ia];
          o_dir_d     = idx_ok && dir_q[ia];
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 8'd0;
      lim_q       <= 8'd0;
      pend_q      <= 1'b0;
      fading_q    <= '0;
      dir_q       <= '0;
      cval_q      <= '0;
      gone_q      <= 8'd0;
      ftot_q      <= 8'd0;
      upd_q       <= 1'b0;
      fio_q       <= 1'b0;
      pcount_q    <= 8'd64;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lim_q       <= lim_d;
      pend_q      <= pend_d;
      fading_q    <= fading_d;
      dir_q       <= dir_d;
      cval_q      <= cval_d;
      gone_q      <= gone_d;
      ftot_q      <= ftot_d;
      upd_q       <= upd_d;
      fio_q       <= fio_d;
      pcount_q    <= pcount_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    idx_q     <= idx_d;
    col_q     <= col_d;
    wr_addr_q <= wr_addr_d;
    o_upd_q   <= o_upd_d;
    o_gone_q  <= o_gone_d;
    o_ftot_q  <= o_ftot_d;
    o_col_q   <= o_col_d;
    o_code_q  <= o_code_d;
    o_fad_q   <= o_fad_d;
    o_dir_q   <= o_dir_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign updated_o       = o_upd_q;
  assign went_out_o      = o_gone_q;
  assign fading_count_o  = o_ftot_q;
  assign pixel_color_o   = o_col_q;
  assign target_code_o   = o_code_q;
  assign is_fading_o     = o_fad_q;
  assign is_increasing_o = o_dir_q;

endmodule

### dv/led_pixel_fade_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pixel_fade_engine_core_tb
// Self-checking bench for the pixel fade engine core.
// A short table of commands covers out-of-range pixels, restarts, stops,
// steps on idle pixels and the spare command codes. It is followed by random
// phases under several register settings and idling mixes, with one long
// result-side hold-off. Each result is checked against its table row where the row
// gives one, else against an in-bench model of the per-pixel colour store, flags and counters.
// ----------------------------------------------------------------------------
module led_pixel_fade_engine_core_tb;

  localparam int CLK_PERIOD      = 4;
  localparam int RESET_CYCLES    = 4;
  localparam int NUM_PX          = 64;
  localparam int PX_AW           = $clog2(NUM_PX);
  localparam int FADE_DIV        = 80;
  localparam int N_DIR           = 26;
  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int HOLD_AT         = 330;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int TAIL_CYCLES     = 100;
  localparam int MAX_PRINTED     = 50;

  // spare command codes, handled like a read
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam logic [7:0] PH_COUNT [N_PHASES] = '{8'd64, 8'd255, 8'd1, 8'd17, 8'd0, 8'd64};
  localparam logic       PH_FADE_IN [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  typedef struct packed {
    logic        updated;
    logic [7:0]  went_out;
    logic [7:0]  fading_count;
    logic [23:0] pixel_color;
    logic [7:0]  target_code;
    logic        is_fading;
    logic        is_increasing;
  } fade_result_t;

  typedef struct packed {
    logic [2:0]   cmd;
    logic [7:0]   idx;
    logic [23:0]  color;
    logic         known;
    fade_result_t res;
  } stim_row_t;

  localparam fade_result_t NO_RES = '0;

  // res fields: updated, went_out, fading_count, colour, code, fading, increasing
  localparam stim_row_t DIR_TAB [N_DIR] = '{
    '{led_pfe_pkg::CMD_READ,    8'd200, 24'h000000, 1'b1, NO_RES},
    '{CMD_RSVD7,                8'd254, 24'h000000, 1'b1, NO_RES},
    '{CMD_RSVD6,                8'd64,  24'hFFFFFF, 1'b1, NO_RES},
    '{led_pfe_pkg::CMD_TICK,    8'd254, 24'h000000, 1'b1, NO_RES},
    '{led_pfe_pkg::CMD_REVERSE, 8'd128, 24'h000000, 1'b1, NO_RES},
    '{led_pfe_pkg::CMD_START,   8'd0,   24'hFFFFFF, 1'b1,
      '{1'b0, 8'd0, 8'd1, 24'h000000, 8'hDB, 1'b1, 1'b1}},
    '{led_pfe_pkg::CMD_START,   8'd63,  24'h000000, 1'b1,
      '{1'b0, 8'd0, 8'd2, 24'h000000, 8'h00, 1'b1, 1'b1}},
    '{led_pfe_pkg::CMD_START,   8'd64,  24'hFFFFFF, 1'b1,
      '{1'b0, 8'd0, 8'd2, 24'h000000, 8'h00, 1'b0, 1'b0}},
    '{led_pfe_pkg::CMD_STEP,    8'd63,  24'h000000, 1'b0, NO_RES},
    '{led_pfe_pkg::CMD_STEP,    8'd63,  24'h000000, 1'b0, NO_RES},
    '{led_pfe_pkg::CMD_STEP,    8'd63,  24'h000000, 1'b0, NO_RES},
    '{led_pfe_pkg::CMD_STEP,    8'd100, 24'h000000, 1'b0, NO_RES},
    '{led_pfe_pkg::CMD_START,   8'd0,   24'h123456, 1'b0, NO_RES},
    '{led_pfe_pkg::CMD_TICK,    8'd0,   24'h000000, 1'b0, NO_RES},
    '{led_pfe_pkg::CMD_STOP,    8'd0,   24'h000000, 1'b0, NO_RES},
    '{led_pfe_pkg::CMD_STOP,    8'd0,   24'h000000, 1'b0, NO_RES},
    '{led_pfe_pkg::CMD_START,   8'd5,   24'h80C040, 1'b0, NO_RES},
    '{led_pfe_pkg::CMD_START,   8'd6,   24'h3F3F3F, 1'b0, NO_RES},
    '{led_pfe_pkg::CMD_REVERSE, 8'd5,   24'h000000, 1'b0, NO_RES},
    '{led_pfe_pkg::CMD_TICK,    8'd6,   24'h000000, 1'b0, NO_RES},
    '{led_pfe_pkg::CMD_TICK,    8'd6,   24'h000000, 1'b0, NO_RES},
    '{led_pfe_pkg::CMD_STOP,    8'd250, 24'h000000, 1'b0, NO_RES},
    '{led_pfe_pkg::CMD_START,   8'd1,   24'hC00000, 1'b0, NO_RES},
    '{CMD_RSVD6,                8'd1,   24'hABCDEF, 1'b0, NO_RES},
    '{CMD_RSVD7,                8'd5,   24'h000000, 1'b0, NO_RES},
    '{led_pfe_pkg::CMD_READ,    8'd0,   24'h000000, 1'b0, NO_RES}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  cmd_i = led_pfe_pkg::CMD_READ;
  logic [7:0]  pixel_index_i = '0;
  logic [23:0] start_color_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        updated_o;
  logic [7:0]  went_out_o;
  logic [7:0]  fading_count_o;
  logic [23:0] pixel_color_o;
  logic [7:0]  target_code_o;
  logic        is_fading_o;
  logic        is_increasing_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = led_pfe_pkg::CFG_FADE_IN_ONLY;
  logic [7:0]  cfg_data_i = '0;

  // typed expectation travelling with the item it belongs to
  logic         row_known = 1'b0;
  fade_result_t row_res = '0;

  // model of the pixel store
  logic [23:0] px_color [NUM_PX] = '{default: '0};
  logic        px_fading [NUM_PX] = '{default: 1'b0};
  logic        px_up [NUM_PX] = '{default: 1'b0};
  logic [7:0]  px_code [NUM_PX] = '{default: '0};
  logic [7:0]  gone_out_cnt = '0;
  logic [7:0]  fading_cnt = '0;
  logic        fade_in_only_q = 1'b0;
  logic [7:0]  walk_count_q = 8'd64;

  fade_result_t due_results [$];
  int           err_cnt = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           started_q [$];
  logic         started_map [NUM_PX] = '{default: 1'b0};

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  led_pixel_fade_engine_core #(
    .NUM_PIXELS(NUM_PX),
    .FADE_STEPS(FADE_DIV)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .pixel_index_i  (pixel_index_i),
    .start_color_i  (start_color_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .updated_o      (updated_o),
    .went_out_o     (went_out_o),
    .fading_count_o (fading_count_o),
    .pixel_color_o  (pixel_color_o),
    .target_code_o  (target_code_o),
    .is_fading_o    (is_fading_o),
    .is_increasing_o(is_increasing_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  function automatic logic [7:0] code_of(logic [23:0] col);
    return (col[23:16] & led_pfe_pkg::CODE_KEEP) |
           ((col[15:8] & led_pfe_pkg::CODE_KEEP) >> 3) |
           ((col[7:0] & led_pfe_pkg::CODE_KEEP) >> 6);
  endfunction

  function automatic logic [23:0] target_of(logic [7:0] code);
    logic [7:0] g;
    logic [7:0] b;
    g = (code & led_pfe_pkg::EXP_G_MASK) << 3;
    b = (code & led_pfe_pkg::EXP_B_MASK) << 6;
    return {code & led_pfe_pkg::EXP_R_MASK, g, b};
  endfunction

  function automatic void stop_pixel(int p);
    if (px_fading[p]) begin
      px_fading[p] = 1'b0;
      if (fading_cnt != 0) fading_cnt--;
    end
  endfunction

  function automatic void fade_pixel(int p);
    logic [23:0] tgt;
    logic [23:0] stp;
    logic [23:0] nxt;
    logic [7:0]  cur;
    logic [7:0]  st;
    logic [7:0]  tg;
    logic [7:0]  v;
    int          hits;
    int          ch;
    tgt  = target_of(px_code[p]);
    hits = 0;
    for (ch = 0; ch < 3; ch++) begin
      // black target moves one count per channel
      stp[ch*8 +: 8] = (tgt == '0) ? 8'd1 : 8'(tgt[ch*8 +: 8] / FADE_DIV + 1);
    end
    for (ch = 0; ch < 3; ch++) begin
      cur = px_color[p][ch*8 +: 8];
      st  = stp[ch*8 +: 8];
      if (px_up[p]) begin
        tg = (cur > tgt[ch*8 +: 8]) ? cur : tgt[ch*8 +: 8];
        if (8'(tg - cur) <= st) begin
          v = tg;
          hits++;
        end else begin
          v = cur + st;
        end
      end else if (cur > st) begin
        v = cur - st;
      end else begin
        v = '0;
        hits++;
      end
      nxt[ch*8 +: 8] = v;
    end
    px_color[p] = nxt;
    if (hits == 3) begin
      if (px_up[p] && !fade_in_only_q) begin
        px_up[p] = 1'b0;
      end else begin
        stop_pixel(p);
        if (gone_out_cnt != 8'hFF) gone_out_cnt++;
      end
    end
  endfunction

  function automatic fade_result_t fade_apply(logic [2:0] c, logic [7:0] ix, logic [23:0] col);
    fade_result_t     r;
    logic             hit;
    logic             upd;
    logic [PX_AW-1:0] a;
    int               n;
    int               p;
    hit = ix < NUM_PX;
    a   = ix[PX_AW-1:0];
    upd = 1'b0;
    n   = (walk_count_q < NUM_PX) ? int'(walk_count_q) : NUM_PX;
    case (c)
      led_pfe_pkg::CMD_START: begin
        if (hit) begin
          if (!px_fading[a]) fading_cnt++;
          px_fading[a] = 1'b1;
          px_up[a]     = 1'b1;
          px_code[a]   = code_of(col);
          px_color[a]  = '0;
        end
      end
      led_pfe_pkg::CMD_TICK: begin
        gone_out_cnt = '0;
        for (p = 0; p < n; p++) begin
          if (px_fading[p]) begin
            upd = 1'b1;
            fade_pixel(p);
          end
        end
      end
      led_pfe_pkg::CMD_STEP: begin
        if (hit && px_fading[a]) begin
          upd = 1'b1;
          fade_pixel(int'(a));
        end
      end
      led_pfe_pkg::CMD_REVERSE: begin
        for (p = 0; p < n; p++) begin
          if (px_fading[p]) px_up[p] = 1'b0;
        end
      end
      led_pfe_pkg::CMD_STOP: begin
        if (hit) stop_pixel(int'(a));
      end
      default: ;
    endcase
    r               = '0;
    r.updated       = upd;
    r.went_out      = gone_out_cnt;
    r.fading_count  = fading_cnt;
    if (hit) begin
      r.pixel_color   = px_color[a];
      r.target_code   = px_code[a];
      r.is_fading     = px_fading[a];
      r.is_increasing = px_up[a];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_cnt < MAX_PRINTED)
      $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // scoreboard and model update, sampled at the edge
  always @(posedge clk_i) begin
    fade_result_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing due", 32'(pixel_color_o), 32'd0);
        end else begin
          e = due_results.pop_front();
          if (updated_o !== e.updated)
            report_mismatch("updated", 32'(updated_o), 32'(e.updated));
          if (went_out_o !== e.went_out)
            report_mismatch("went_out", 32'(went_out_o), 32'(e.went_out));
          if (fading_count_o !== e.fading_count)
            report_mismatch("fading_count", 32'(fading_count_o), 32'(e.fading_count));
          if (pixel_color_o !== e.pixel_color)
            report_mismatch("pixel_color", 32'(pixel_color_o), 32'(e.pixel_color));
          if (target_code_o !== e.target_code)
            report_mismatch("target_code", 32'(target_code_o), 32'(e.target_code));
          if (is_fading_o !== e.is_fading)
            report_mismatch("is_fading", 32'(is_fading_o), 32'(e.is_fading));
          if (is_increasing_o !== e.is_increasing)
            report_mismatch("is_increasing", 32'(is_increasing_o), 32'(e.is_increasing));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == led_pfe_pkg::CFG_FADE_IN_ONLY) fade_in_only_q = cfg_data_i[0];
        else if (cfg_index_i == led_pfe_pkg::CFG_PIXEL_COUNT) walk_count_q = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        e = fade_apply(cmd_i, pixel_index_i, start_color_i);
        due_results.push_back(row_known ? row_res : e);
      end
    end
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    int taken;
    int hold_left;
    bit held;
    if (rst_ni && out_valid_o && out_ready_i) taken++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!held && taken >= HOLD_AT) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni)
        quiet = 0;
      else
        quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic offer_item(logic [2:0] c, logic [7:0] ix, logic [23:0] col, logic known,
                            fade_result_t res);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    if (c == led_pfe_pkg::CMD_START && ix < NUM_PX && !started_map[ix[PX_AW-1:0]]) begin
      started_map[ix[PX_AW-1:0]] = 1'b1;
      started_q.push_back(int'(ix));
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    pixel_index_i <= ix;
    start_color_i <= col;
    row_known     <= known;
    row_res       <= res;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic pick_item(output logic [2:0] c, output logic [7:0] ix, output logic [23:0] col);
    int r;
    r = $urandom_range(0, 99);
    if (r < 9) c = led_pfe_pkg::CMD_START;
    else if (r < 52) c = led_pfe_pkg::CMD_TICK;
    else if (r < 72) c = led_pfe_pkg::CMD_STEP;
    else if (r < 77) c = led_pfe_pkg::CMD_REVERSE;
    else if (r < 81) c = led_pfe_pkg::CMD_STOP;
    else if (r < 93) c = led_pfe_pkg::CMD_READ;
    else c = 3'($urandom_range(CMD_RSVD6, CMD_RSVD7));
    // about four in ten targets reduce to black and turn round, or go out in fade-in-only mode, at once
    col = 24'($urandom());
    if ($urandom_range(0, 9) < 4) col = col & 24'h3F3F3F;
    if ($urandom_range(0, 99) < 12) begin
      ix = 8'($urandom_range(NUM_PX, 254));
    end else if (c == led_pfe_pkg::CMD_START) begin
      ix = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, NUM_PX - 1))
                                       : 8'($urandom_range(0, 11));
    end else begin
      // in range, other commands address only pixels with a written target code
      ix = 8'(started_q[$urandom_range(0, started_q.size() - 1)]);
    end
  endtask

  task automatic drain;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(logic fade_in, logic [7:0] count);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= led_pfe_pkg::CFG_FADE_IN_ONLY;
    cfg_data_i  <= {7'd0, fade_in};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= led_pfe_pkg::CFG_PIXEL_COUNT;
    cfg_data_i  <= count;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [2:0]  c;
    logic [7:0]  ix;
    logic [23:0] col;
    int          i;
    int          ph;
    int          k;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 33;
    recv_idle_pct = 64;
    for (i = 0; i < N_DIR; i++)
      offer_item(DIR_TAB[i].cmd, DIR_TAB[i].idx, DIR_TAB[i].color, DIR_TAB[i].known,
                 DIR_TAB[i].res);
    in_valid_i <= 1'b0;

    for (ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph / 2)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_regs(PH_FADE_IN[ph], PH_COUNT[ph]);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick_item(c, ix, col);
        offer_item(c, ix, col, 1'b0, NO_RES);
      end
      in_valid_i <= 1'b0;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && due_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
